// ===== src/clsb_pkg.sv =====
package clsb_pkg;

    localparam int WORD_BITS = 32;
    localparam int CHUNK_LSB = 7;
    localparam int POS_W     = $clog2(WORD_BITS - CHUNK_LSB);
    localparam int CNT_W     = $clog2(2 * (WORD_BITS / 8) + 5);
    localparam int OUT_MAX   = 8;
    localparam int IDX_W     = $clog2(OUT_MAX);
    localparam int VALUE_W   = 32;
    localparam int REG_W     = 4;
    localparam int LIT_W     = 8;
    localparam int KIND_W    = 3;
    localparam int S_TDATA_W = ((VALUE_W + REG_W + 7) / 8) * 8;
    localparam int M_FIELD_W = KIND_W + REG_W + LIT_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        OP_MOV = 3'd0,
        OP_ADD = 3'd1,
        OP_SHL = 3'd2,
        OP_NEG = 3'd3,
        OP_NOT = 3'd4
    } op_kind_t;

    // one scheduled request for the emitter
    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        op_kind_t             tail_kind;
        logic [REG_W-1:0]     dest;
        logic [IDX_W-1:0]     last_idx;
    } desc_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pos;
    } top_t;

    // highest set bit at or above CHUNK_LSB; pos is the chunk's low bit
    function automatic top_t find_top(input logic [WORD_BITS-1:0] w);
        top_t r;
        r = '0;
        for (int j = CHUNK_LSB; j < WORD_BITS; j++) begin
            if (w[j]) begin
                r.found = 1'b1;
                r.pos   = POS_W'(j - CHUNK_LSB);
            end
        end
        return r;
    endfunction

    function automatic logic [WORD_BITS-1:0] clear_chunk(input logic [WORD_BITS-1:0] w,
                                                         input logic [POS_W-1:0] pos);
        logic [WORD_BITS-1:0] m;
        m = {{(WORD_BITS-LIT_W){1'b0}}, {LIT_W{1'b1}}} << pos;
        return w & ~m;
    endfunction

    function automatic logic [LIT_W-1:0] chunk_at(input logic [WORD_BITS-1:0] w,
                                                  input logic [POS_W-1:0] pos);
        logic [WORD_BITS-1:0] s;
        s = w >> pos;
        return s[LIT_W-1:0];
    endfunction

endpackage

// ===== src/clsb_front.sv =====
module clsb_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [clsb_pkg::VALUE_W-1:0]    in_value,
    input  logic [clsb_pkg::REG_W-1:0]      in_dest,
    output logic                            push,
    output clsb_pkg::desc_t                 push_desc,
    input  logic                            q_full
);
    import clsb_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SCAN = 3'b010,
        F_DONE = 3'b100
    } fstate_t;

    fstate_t              state_reg, state_next;
    logic [WORD_BITS-1:0] w_reg    [3];
    logic [WORD_BITS-1:0] orig_reg [3];
    logic                 have_reg [3];
    logic [POS_W-1:0]     prev_reg [3];
    logic [CNT_W-1:0]     n_reg    [3];
    logic [REG_W-1:0]     dst_reg;

    top_t                 tp       [3];
    logic [CNT_W-1:0]     fin_n    [3];
    logic [WORD_BITS-1:0] start_w  [3];
    logic                 any_found;
    logic                 accept;
    logic [1:0]           best;
    logic [CNT_W-1:0]     best_n;

    assign accept = in_valid && in_ready;

    always_comb begin
        start_w[0] = WORD_BITS'(in_value);
        start_w[1] = WORD_BITS'(0) - start_w[0];
        start_w[2] = ~start_w[0];
        any_found  = 1'b0;
        for (int v = 0; v < 3; v++) begin
            tp[v]     = find_top(w_reg[v]);
            any_found = any_found | tp[v].found;
            // closing ops: lone move, or trailing shift and add; plus negate/not
            if (!have_reg[v]) begin
                fin_n[v] = n_reg[v] + CNT_W'(1);
            end else begin
                fin_n[v] = n_reg[v] + CNT_W'(prev_reg[v] != '0) + CNT_W'(w_reg[v] != '0);
            end
            if (v != 0) begin
                fin_n[v] = fin_n[v] + CNT_W'(1);
            end
        end
    end

    // earlier variant wins a tie
    always_comb begin
        best   = 2'd0;
        best_n = n_reg[0];
        if (n_reg[1] < best_n) begin
            best   = 2'd1;
            best_n = n_reg[1];
        end
        if (n_reg[2] < best_n) begin
            best   = 2'd2;
            best_n = n_reg[2];
        end
    end

    always_comb begin
        push_desc.word      = orig_reg[best];
        push_desc.dest      = dst_reg;
        push_desc.tail_kind = (best == 2'd1) ? OP_NEG : (best == 2'd2) ? OP_NOT : OP_MOV;
        if (best_n >= CNT_W'(OUT_MAX)) begin
            push_desc.last_idx = IDX_W'(OUT_MAX - 1);
        end else begin
            push_desc.last_idx = IDX_W'(best_n - CNT_W'(1));
        end
    end

    assign push     = (state_reg == F_DONE) && !q_full;
    assign in_ready = (state_reg == F_IDLE) || push;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) state_next = F_SCAN;
            end
            F_SCAN: begin
                if (!any_found) state_next = F_DONE;
            end
            F_DONE: begin
                if (accept)    state_next = F_SCAN;
                else if (push) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dst_reg <= in_dest;
            for (int v = 0; v < 3; v++) begin
                w_reg[v]    <= start_w[v];
                orig_reg[v] <= start_w[v];
                have_reg[v] <= 1'b0;
                prev_reg[v] <= '0;
                n_reg[v]    <= '0;
            end
        end else if (state_reg == F_SCAN) begin
            for (int v = 0; v < 3; v++) begin
                if (!any_found) begin
                    n_reg[v] <= fin_n[v];
                end else if (tp[v].found) begin
                    w_reg[v]    <= clear_chunk(w_reg[v], tp[v].pos);
                    prev_reg[v] <= tp[v].pos;
                    have_reg[v] <= 1'b1;
                    n_reg[v]    <= n_reg[v] + (have_reg[v] ? CNT_W'(2) : CNT_W'(1));
                end
            end
        end
    end

endmodule

// ===== src/clsb_queue.sv =====
module clsb_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  clsb_pkg::desc_t push_desc,
    output logic            full,
    input  logic            pop,
    output clsb_pkg::desc_t pop_desc,
    output logic            not_empty
);
    import clsb_pkg::*;

    desc_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] cnt_reg;

    assign full      = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_desc  = mem_reg[rd_ptr_reg];

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)      cnt_reg <= cnt_reg + Q_CNT_W'(1);
            else if (pop && !push) cnt_reg <= cnt_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

// ===== src/clsb_back.sv =====
module clsb_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  clsb_pkg::desc_t            q_desc,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output clsb_pkg::op_kind_t         out_kind,
    output logic [clsb_pkg::REG_W-1:0] out_dest,
    output logic [clsb_pkg::LIT_W-1:0] out_lit,
    output logic                       out_last
);
    import clsb_pkg::*;

    typedef enum logic [2:0] {
        B_CHUNK = 3'b001,
        B_FADD  = 3'b010,
        B_TAIL  = 3'b100
    } bphase_t;

    logic                 busy_reg;
    bphase_t              phase_reg, phase_next;
    logic [WORD_BITS-1:0] w_reg, w_next;
    logic                 have_reg, have_next;
    logic                 pend_reg, pend_next;
    logic [POS_W-1:0]     prev_reg, prev_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     last_idx_reg;
    op_kind_t             tail_reg;
    logic [REG_W-1:0]     dst_reg;

    logic                 valid_reg;
    op_kind_t             kind_reg, kind_next;
    logic [LIT_W-1:0]     lit_reg, lit_next;
    logic                 last_reg;
    logic [REG_W-1:0]     odest_reg;

    top_t                 tp;
    logic                 emit;
    logic                 is_last;
    logic                 load;

    assign emit    = busy_reg && (!valid_reg || out_ready);
    assign is_last = (idx_reg == last_idx_reg);
    assign load    = q_valid && (!busy_reg || (emit && is_last));
    assign pop     = load;

    always_comb begin
        tp         = find_top(w_reg);
        w_next     = w_reg;
        have_next  = have_reg;
        pend_next  = pend_reg;
        prev_next  = prev_reg;
        phase_next = phase_reg;
        kind_next  = tail_reg;
        lit_next   = '0;
        unique case (phase_reg)
            B_CHUNK: begin
                if (pend_reg) begin
                    // add of the chunk whose shift was the previous instruction emitted
                    kind_next = OP_ADD;
                    lit_next  = chunk_at(w_reg, prev_reg);
                    w_next    = clear_chunk(w_reg, prev_reg);
                    pend_next = 1'b0;
                end else if (tp.found && !have_reg) begin
                    kind_next = OP_MOV;
                    lit_next  = chunk_at(w_reg, tp.pos);
                    w_next    = clear_chunk(w_reg, tp.pos);
                    have_next = 1'b1;
                    prev_next = tp.pos;
                end else if (tp.found) begin
                    kind_next = OP_SHL;
                    lit_next  = LIT_W'(prev_reg - tp.pos);
                    prev_next = tp.pos;
                    pend_next = 1'b1;
                end else if (!have_reg) begin
                    kind_next  = OP_MOV;
                    lit_next   = w_reg[LIT_W-1:0];
                    phase_next = B_TAIL;
                end else if (prev_reg != '0) begin
                    kind_next  = OP_SHL;
                    lit_next   = LIT_W'(prev_reg);
                    phase_next = B_FADD;
                end else if (w_reg != '0) begin
                    kind_next  = OP_ADD;
                    lit_next   = w_reg[LIT_W-1:0];
                    phase_next = B_TAIL;
                end
            end
            B_FADD: begin
                if (w_reg != '0) begin
                    kind_next  = OP_ADD;
                    lit_next   = w_reg[LIT_W-1:0];
                    phase_next = B_TAIL;
                end
            end
            B_TAIL: begin
                kind_next = tail_reg;
            end
            default: phase_next = B_CHUNK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            phase_reg <= B_CHUNK;
            pend_reg  <= 1'b0;
            have_reg  <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                busy_reg  <= 1'b1;
                phase_reg <= B_CHUNK;
                pend_reg  <= 1'b0;
                have_reg  <= 1'b0;
                idx_reg   <= '0;
            end else if (emit) begin
                busy_reg  <= !is_last;
                phase_reg <= phase_next;
                pend_reg  <= pend_next;
                have_reg  <= have_next;
                idx_reg   <= idx_reg + IDX_W'(1);
            end
            if (emit)           valid_reg <= 1'b1;
            else if (out_ready) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            w_reg        <= q_desc.word;
            prev_reg     <= '0;
            last_idx_reg <= q_desc.last_idx;
            tail_reg     <= q_desc.tail_kind;
            dst_reg      <= q_desc.dest;
        end else if (emit) begin
            w_reg    <= w_next;
            prev_reg <= prev_next;
        end
        if (emit) begin
            kind_reg  <= kind_next;
            lit_reg   <= lit_next;
            last_reg  <= is_last;
            odest_reg <= dst_reg;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_lit   = lit_reg;
    assign out_last  = last_reg;
    assign out_dest  = odest_reg;

endmodule

// ===== src/constant_load_sequence_builder.sv =====
// Constant load sequence builder.
// Input stream: one request per constant. s_tdata carries the 32-bit value and
// the destination register number. Output stream: one request per emitted
// instruction (op kind, register, literal); m_tlast marks the final one of a run.
// Runs are 1 to 8 instructions long. The front end scans the value, its
// negation and its complement in parallel, taking one 8-bit chunk per variant
// per cycle (zero to four chunks), picks the shortest run and queues a short
// descriptor. The back end rescans the chosen word and emits one instruction
// per cycle into the output register unless a result waits there with m_tready low.
// Overlap: the front end accepts the next constant as its descriptor is pushed;
// the emitter loads the next queued descriptor while it emits the last
// instruction of the current run. The slower side sets the rate.
// The front end keeps taking items while results wait: the two-entry
// descriptor queue and the output register decouple the sides.
// Stall: m_tready low holds the output register; the emitter, then the queue,
// then s_tready back up in turn. Nothing is dropped.
// Reset (aresetn low, synchronous) empties the queue and clears all control;
// no item is in flight afterwards.
module constant_load_sequence_builder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [31:0] value, [35:32] dest_register, [39:36] zero
    input  logic [clsb_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [2:0] op_kind, [6:3] target_register, [14:7] literal, [15] zero
    output logic [clsb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);
    import clsb_pkg::*;

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_valid;
    desc_t            push_desc;
    desc_t            pop_desc;
    op_kind_t         out_kind;
    logic [REG_W-1:0] out_dest;
    logic [LIT_W-1:0] out_lit;
    logic             start_reg;

    clsb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .in_dest   (s_tdata[VALUE_W+REG_W-1:VALUE_W]),
        .push      (q_push),
        .push_desc (push_desc),
        .q_full    (q_full)
    );

    // decouples scanning from emission
    clsb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .pop_desc  (pop_desc),
        .not_empty (q_valid)
    );

    clsb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_desc    (pop_desc),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_dest  (out_dest),
        .out_lit   (out_lit),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(M_TDATA_W-M_FIELD_W){1'b0}}, out_lit, out_dest, out_kind};

    // marks that the next output request opens a new run
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            start_reg <= m_tlast;
        end
    end

    a_run_opens_with_move: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && start_reg) |-> (out_kind == OP_MOV))
        else $error("run does not open with a move");

    a_tail_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_kind == OP_NEG || out_kind == OP_NOT)) |-> (m_tlast && out_lit == '0))
        else $error("negate/not not final or carries a literal");

    a_no_queue_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("descriptor queue overflow");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty descriptor queue");

endmodule

// ===== tb/constant_load_sequence_builder_tb.sv =====
module constant_load_sequence_builder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clsb_pkg::*;

    // Run sizes and idle shaping
    localparam int RAND_REQS   = 250;
    localparam int MAX_GAP     = 6;
    localparam int HOLD_CYCLES = 150;   // long receiver hold-off, fills the front end
    localparam int HOLD_AT     = 40;    // random request index that triggers it
    localparam int DRAIN_TAIL  = 20;    // cycles after the last result

    // One emitted instruction as seen on the result stream
    typedef struct packed {
        op_kind_t          kind;
        logic [REG_W-1:0]  rd;
        logic [LIT_W-1:0]  lit;
        logic              last;
    } instr_t;

    // Directed row: nops == 0 means "ask the run planner", otherwise the run is
    // typed in here (at most two instructions, readable at a glance)
    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [REG_W-1:0]   dest;
        int                 nops;
        op_kind_t           k0;
        logic [LIT_W-1:0]   l0;
        op_kind_t           k1;
        logic [LIT_W-1:0]   l1;
    } dir_row_t;

    localparam int N_DIR = 22;

    dir_row_t dir_tbl [N_DIR] = '{
        // zero: single move of 0
        '{32'h0000_0000, 4'd0,  1, OP_MOV, 8'h00, OP_MOV, 8'h00},
        // all ones: negation (1) and complement (0) tie at two, negation wins
        '{32'hFFFF_FFFF, 4'd15, 2, OP_MOV, 8'h01, OP_NEG, 8'h00},
        // top bit alone: one chunk then shift by its position
        '{32'h8000_0000, 4'd15, 2, OP_MOV, 8'h80, OP_SHL, 8'd24},
        // below bit 7 only: lone move
        '{32'h0000_007F, 4'd5,  1, OP_MOV, 8'h7F, OP_MOV, 8'h00},
        '{32'h0000_0001, 4'd1,  1, OP_MOV, 8'h01, OP_MOV, 8'h00},
        // chunk at position zero: no trailing shift
        '{32'h0000_0080, 4'd10, 1, OP_MOV, 8'h80, OP_MOV, 8'h00},
        '{32'h0000_0100, 4'd3,  2, OP_MOV, 8'h80, OP_SHL, 8'd1},
        // complement wins
        '{32'hFFFF_FF00, 4'd0,  2, OP_MOV, 8'hFF, OP_NOT, 8'h00},
        // negation and complement tie again
        '{32'hFFFF_FF80, 4'd7,  2, OP_MOV, 8'h80, OP_NEG, 8'h00},
        '{32'h0000_0080, 4'd15, 1, OP_MOV, 8'h80, OP_MOV, 8'h00},
        // the rest go through the planner
        '{32'h7FFF_FFFF, 4'd2,  0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'h8080_8081, 4'd15, 0, OP_MOV, 8'h00, OP_MOV, 8'h00},  // longest run
        '{32'h8080_8080, 4'd0,  0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'h1234_5678, 4'd4,  0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'hDEAD_BEEF, 4'd9,  0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'h00FF_00FF, 4'd11, 0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'h5555_5555, 4'd12, 0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'hAAAA_AAAA, 4'd13, 0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'h0000_FFFF, 4'd14, 0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'hFFFF_0000, 4'd6,  0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'h4000_0001, 4'd8,  0, OP_MOV, 8'h00, OP_MOV, 8'h00},
        '{32'hFFFF_FF7F, 4'd1,  0, OP_MOV, 8'h00, OP_MOV, 8'h00}
    };

    // DUT ports
    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    // Scoreboard state
    instr_t   pending_instrs [$];   // instructions still owed by the block, in order
    dir_row_t hand_runs [$];        // per offered request: typed run or planner marker
    int       fails      = 0;
    int       n_reqs     = 0;
    int       n_instrs   = 0;
    int       kind_cnt [5] = '{default: 0};
    int       run_len    = 0;
    int       longest    = 0;

    // Idle shaping: no_idle serves both sides, hold_off the receiver
    bit       no_idle  = 1'b0;      // stretch with back-to-back traffic
    bit       hold_off = 1'b0;      // one-shot long stall request for the receiver

    constant_load_sequence_builder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Walk one variant: chunks of 8 bits topped by each set bit from the top down
    // to bit 7, shifts relative between chunks, then the leftover low bits.
    function automatic int chunk_walk(input logic [WORD_BITS-1:0] w_in,
                                      input bit tail, input op_kind_t tail_kind,
                                      output op_kind_t kd [12], output logic [LIT_W-1:0] lt [12]);
        logic [WORD_BITS-1:0] w;
        logic [WORD_BITS-1:0] sh;
        int n;
        int prev;
        int pos;
        bit have;
        w    = w_in;
        n    = 0;
        prev = 0;
        have = 1'b0;
        for (int i = 0; i < 12; i++) begin
            kd[i] = OP_MOV;
            lt[i] = '0;
        end
        for (int j = WORD_BITS - 1; j >= CHUNK_LSB; j--) begin
            if (w[j]) begin
                pos = j - CHUNK_LSB;
                sh  = w >> pos;
                if (!have) begin
                    kd[n] = OP_MOV; lt[n] = sh[LIT_W-1:0]; n++;
                end else begin
                    kd[n] = OP_SHL; lt[n] = LIT_W'(prev - pos); n++;
                    kd[n] = OP_ADD; lt[n] = sh[LIT_W-1:0]; n++;
                end
                w    = w & ~({{(WORD_BITS-LIT_W){1'b0}}, {LIT_W{1'b1}}} << pos);
                prev = pos;
                have = 1'b1;
            end
        end
        if (!have) begin
            kd[n] = OP_MOV; lt[n] = w[LIT_W-1:0]; n++;
        end else begin
            if (prev > 0) begin
                kd[n] = OP_SHL; lt[n] = LIT_W'(prev); n++;
            end
            if (w != '0) begin
                kd[n] = OP_ADD; lt[n] = w[LIT_W-1:0]; n++;
            end
        end
        if (tail) begin
            kd[n] = tail_kind; lt[n] = '0; n++;
        end
        return n;
    endfunction

    // Shortest of plain / negated / complemented run; ties go to the earlier one
    function automatic void plan_load_run(input logic [VALUE_W-1:0] value,
                                          input logic [REG_W-1:0] dest);
        op_kind_t         kd [3][12];
        logic [LIT_W-1:0] lt [3][12];
        int               n [3];
        int               best;
        int               cnt;
        instr_t           ins;
        n[0] = chunk_walk(WORD_BITS'(value),          1'b0, OP_MOV, kd[0], lt[0]);
        n[1] = chunk_walk(WORD_BITS'(-value),         1'b1, OP_NEG, kd[1], lt[1]);
        n[2] = chunk_walk(WORD_BITS'(~value),         1'b1, OP_NOT, kd[2], lt[2]);
        best = 0;
        if (n[1] < n[best]) best = 1;
        if (n[2] < n[best]) best = 2;
        cnt = (n[best] > OUT_MAX) ? OUT_MAX : n[best];
        for (int k = 0; k < cnt; k++) begin
            ins.kind = kd[best][k];
            ins.rd   = dest;
            ins.lit  = lt[best][k];
            ins.last = (k == cnt - 1);
            pending_instrs.insert(pending_instrs.size(), ins);
        end
    endfunction

    // Offer one request after an idle gap; returns once it is taken.
    // With gap 0 tvalid stays high straight into the next request.
    task automatic offer_req(input logic [VALUE_W-1:0] value, input logic [REG_W-1:0] dest,
                             input dir_row_t row);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        hand_runs.insert(hand_runs.size(), row);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-VALUE_W-REG_W){1'b0}}, dest, value};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Random constant drawn from shapes that hit each variant and run length
    function automatic logic [VALUE_W-1:0] draw_value();
        logic [VALUE_W-1:0] v;
        int shape;
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1, 2: v = $urandom();                                  // anything
            3:       v = $urandom_range(0, 255);                      // short literal
            4:       v = -VALUE_W'($urandom_range(0, 255));           // small negative
            5:       v = ~VALUE_W'($urandom_range(0, 255));           // near all ones
            6: begin                                                  // a few scattered bits
                v = '0;
                repeat ($urandom_range(1, 4))
                    v |= VALUE_W'($urandom_range(1, 255)) << $urandom_range(0, 24);
            end
            7:       v = $urandom() | 32'h8080_8080;                  // four chunks, long runs
            8: begin                                                  // single bit or its negation
                v = VALUE_W'(1) << $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = {8'hFF, 24'($urandom())};                    // high byte all ones
        endcase
        return v;
    endfunction

    // Main stimulus: reset, directed table, random requests, drain, verdict
    initial begin
        dir_row_t planner_row;
        planner_row = dir_tbl[N_DIR - 1];
        planner_row.nops = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tbl[i])
            offer_req(dir_tbl[i].value, dir_tbl[i].dest, dir_tbl[i]);

        for (int i = 0; i < RAND_REQS; i++) begin
            if (i % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (i == HOLD_AT) begin
                no_idle  = 1'b1;        // keep offering back to back while stalled
                hold_off = 1'b1;
            end
            offer_req(draw_value(), REG_W'($urandom_range(0, 15)), planner_row);
        end
        s_tvalid <= 1'b0;

        while (pending_instrs.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("Covered %0d requests, %0d instructions (mov %0d add %0d shl %0d neg %0d not %0d)",
                 n_reqs, n_instrs, kind_cnt[OP_MOV], kind_cnt[OP_ADD], kind_cnt[OP_SHL],
                 kind_cnt[OP_NEG], kind_cnt[OP_NOT]);
        $display("Longest run seen: %0d instructions, including one %0d-cycle output stall",
                 longest, HOLD_CYCLES);
        if (fails == 0)
            $display("constant_load_sequence_builder regression: pass");
        else
            $display("constant_load_sequence_builder regression: fail");
        $finish;
    end

    // Receiver: random stall per result, one long hold-off on request
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off) begin
                stall    = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Scoreboard: input handshakes feed the owed list, output handshakes drain it.
    // Input side first, though a result can never share the edge of its request.
    always @(posedge aclk) begin : scoreboard
        dir_row_t row;
        instr_t   want;
        instr_t   got;
        instr_t   ins;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                n_reqs++;
                if (hand_runs.size() == 0) begin
                    $error("request accepted with nothing offered");
                    fails++;
                end else begin
                    row = hand_runs.pop_front();
                    if (row.nops == 0) begin
                        plan_load_run(s_tdata[VALUE_W-1:0], s_tdata[VALUE_W +: REG_W]);
                    end else begin
                        ins.kind = row.k0;
                        ins.rd   = row.dest;
                        ins.lit  = row.l0;
                        ins.last = (row.nops == 1);
                        pending_instrs.insert(pending_instrs.size(), ins);
                        if (row.nops == 2) begin
                            ins.kind = row.k1;
                            ins.lit  = row.l1;
                            ins.last = 1'b1;
                            pending_instrs.insert(pending_instrs.size(), ins);
                        end
                    end
                end
            end
            if (m_tvalid && m_tready) begin
                got.kind = op_kind_t'(m_tdata[KIND_W-1:0]);
                got.rd   = m_tdata[KIND_W +: REG_W];
                got.lit  = m_tdata[KIND_W + REG_W +: LIT_W];
                got.last = m_tlast;
                n_instrs++;
                if (got.kind <= OP_NOT) kind_cnt[got.kind]++;
                run_len++;
                if (got.last) begin
                    if (run_len > longest) longest = run_len;
                    run_len = 0;
                end
                if (pending_instrs.size() == 0) begin
                    $error("unexpected instruction: kind %0d reg %0d literal 0x%02h last %0b",
                           got.kind, got.rd, got.lit, got.last);
                    fails++;
                end else begin
                    want = pending_instrs.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("op_kind: expected %0d, got %0d", want.kind, got.kind);
                        fails++;
                    end
                    if (got.rd !== want.rd) begin
                        $error("target_register: expected %0d, got %0d", want.rd, got.rd);
                        fails++;
                    end
                    if (got.lit !== want.lit) begin
                        $error("literal: expected 0x%02h, got 0x%02h", want.lit, got.lit);
                        fails++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, got.last);
                        fails++;
                    end
                end
            end
        end
    end

    // Watchdog: reports fail and stops if the regression hangs
    initial begin
        #4_000_000;
        $display("constant_load_sequence_builder regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/clsb_pkg.sv
src/clsb_front.sv
src/clsb_queue.sv
src/clsb_back.sv
src/constant_load_sequence_builder.sv
tb/constant_load_sequence_builder_tb.sv
